// ----- rtl/artv_pkg.sv -----
// Shared types, constants and table functions of the axis rotate/translate pipeline.
package artv_pkg;

  localparam int CORDIC_STAGES = 16;
  // Clamp the stage count to the supported span
  localparam int NSTG = (CORDIC_STAGES < 8) ? 8 : ((CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES);

  localparam int CW = 32;          // coordinate width, Q16.16
  localparam int PW = CW + 18;     // rotated pair, 32 fraction bits plus growth
  localparam int AW = 42;          // residual angle, degrees with 32 fraction bits

  // One full turn is 360 * 2^16 = 45 * 2^19; reduce on units of 2^19
  localparam int FOLD_SHIFT  = 19;
  localparam int MOD_UNITS   = (360 * 65536) >> FOLD_SHIFT;
  localparam int UW          = $clog2(MOD_UNITS);
  localparam int HW          = CW - FOLD_SHIFT;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_UNITS = ((1 << RECIP_SHIFT) + MOD_UNITS - 1) / MOD_UNITS;
  localparam int RECIP_W     = $clog2(RECIP_UNITS + 1);
  localparam int QW          = HW + RECIP_W - RECIP_SHIFT;
  localparam int RW          = UW + FOLD_SHIFT;

  localparam logic [RW-1:0] DEG_QUARTER = RW'(90 * 65536);
  localparam logic [RW-1:0] DEG_HALF    = RW'(180 * 65536);
  localparam logic [RW-1:0] DEG_3Q      = RW'(270 * 65536);
  localparam logic [RW-1:0] DEG_FULL    = RW'(360 * 65536);

  localparam longint RAD_TO_DEG_Q32 = 64'sd246083499208;
  localparam longint GAIN_LIMIT_Q32 = 64'sd2608131496;

  typedef enum logic [2:0] {
    KIND_ROT_X = 3'd0,
    KIND_ROT_Y = 3'd1,
    KIND_ROT_Z = 3'd2,
    KIND_ADD_X = 3'd3,
    KIND_ADD_Y = 3'd4,
    KIND_ADD_Z = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]    kind;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [CW-1:0] amt;
  } item_t;

  typedef struct packed {
    item_t         item;
    logic [PW-1:0] pa;
    logic [PW-1:0] pb;
    logic [AW-1:0] ang;
  } rot_t;

  typedef struct packed {
    logic          sat;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } res_t;

  typedef struct packed {
    logic          sat;
    logic [CW-1:0] val;
  } clip_t;

  // atan(2^-i) in degrees, scaled by 2^32
  function automatic longint atan_entry(input int i);
    longint t;
    case (i)
      0:       t = 64'sd193273528320;
      1:       t = 64'sd114096026022;
      2:       t = 64'sd60285206653;
      3:       t = 64'sd30601712202;
      4:       t = 64'sd15360239180;
      5:       t = 64'sd7687607525;
      6:       t = 64'sd3844741810;
      7:       t = 64'sd1922488225;
      8:       t = 64'sd961258780;
      9:       t = 64'sd480631223;
      10:      t = 64'sd240315841;
      11:      t = 64'sd120157949;
      12:      t = 64'sd60078978;
      13:      t = 64'sd30039489;
      14:      t = 64'sd15019745;
      15:      t = 64'sd7509872;
      default: t = (RAD_TO_DEG_Q32 + (64'sd1 <<< (i - 1))) >>> i;
    endcase
    return t;
  endfunction

  // 1/K for n stages, scaled by 2^32
  function automatic longint gain_of(input int n);
    longint g;
    case (n)
      8:       g = 64'sd2608158028;
      9:       g = 64'sd2608138129;
      10:      g = 64'sd2608133154;
      11:      g = 64'sd2608131911;
      12:      g = 64'sd2608131600;
      13:      g = 64'sd2608131522;
      14:      g = 64'sd2608131503;
      15:      g = 64'sd2608131498;
      16:      g = 64'sd2608131497;
      default: g = GAIN_LIMIT_Q32;
    endcase
    return g;
  endfunction

  localparam logic signed [32:0] GAIN_Q32 = 33'(gain_of(NSTG));

  // Clip a signed value two bits wider than a coordinate to the coordinate range
  function automatic clip_t clip_coord(input logic [CW+1:0] v);
    clip_t c;
    if (v[CW+1:CW-1] == 3'b000 || v[CW+1:CW-1] == 3'b111) begin
      c.sat = 1'b0;
      c.val = v[CW-1:0];
    end else begin
      c.sat = 1'b1;
      c.val = v[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    return c;
  endfunction

endpackage

// ----- rtl/artv_prep.sv -----
// Angle reduction, gain scaling and quadrant fold: two pipeline stages.
module artv_prep import artv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output rot_t  out_rot_o
);

  logic              s1_v_q, s2_v_q;
  logic              s1_rdy, s2_rdy;
  item_t             s1_item_q;
  logic [RW-1:0]     s1_r_q, s1_r_d;
  logic [PW-1:0]     s1_pa_q, s1_pb_q, s1_pa_d, s1_pb_d;
  rot_t              s2_rot_q, s2_rot_d;

  logic [HW-1:0]          hi;
  logic [HW+RECIP_W-1:0]  q_prod;
  logic [QW-1:0]          q_est;
  logic [HW:0]            q45, rem_raw, rem_fix;
  logic [UW-1:0]          unit, unit_adj;
  logic [CW-1:0]          a_sel, b_sel;
  logic signed [CW+33:0]  prod_a, prod_b;
  logic signed [RW:0]     deg;
  logic                   flip;

  assign s2_rdy     = !s2_v_q || out_ready_i;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  // Stage 1: amount modulo one turn, pair select, gain multiply
  always_comb begin
    // offset binary; 2^31 is exactly one unit past a whole number of turns
    hi       = {~in_item_i.amt[CW-1], in_item_i.amt[CW-2:FOLD_SHIFT]};
    q_prod   = (HW+RECIP_W)'(hi) * (HW+RECIP_W)'(RECIP_UNITS);
    q_est    = q_prod[HW+RECIP_W-1:RECIP_SHIFT];
    q45      = ((HW+1)'(q_est) << 5) + ((HW+1)'(q_est) << 3) + ((HW+1)'(q_est) << 2)
             + (HW+1)'(q_est);
    rem_raw  = {1'b0, hi} - q45;
    // estimate overshoots by at most one
    rem_fix  = rem_raw[HW] ? rem_raw + (HW+1)'(MOD_UNITS) : rem_raw;
    unit     = rem_fix[UW-1:0];
    unit_adj = (unit == '0) ? UW'(MOD_UNITS - 1) : unit - UW'(1);
    s1_r_d   = {unit_adj, in_item_i.amt[FOLD_SHIFT-1:0]};

    case (in_item_i.kind)
      KIND_ROT_X: begin
        a_sel = in_item_i.y;
        b_sel = in_item_i.z;
      end
      KIND_ROT_Y: begin
        a_sel = in_item_i.z;
        b_sel = in_item_i.x;
      end
      default: begin
        a_sel = in_item_i.x;
        b_sel = in_item_i.y;
      end
    endcase
    prod_a  = $signed(a_sel) * GAIN_Q32;
    prod_b  = $signed(b_sel) * GAIN_Q32;
    s1_pa_d = prod_a[16 +: PW];
    s1_pb_d = prod_b[16 +: PW];
  end

  // Stage 2: fold into plus or minus a quarter turn
  always_comb begin
    if (s1_r_q <= DEG_QUARTER) begin
      deg  = $signed({1'b0, s1_r_q});
      flip = 1'b0;
    end else if (s1_r_q < DEG_3Q) begin
      deg  = $signed({1'b0, s1_r_q}) - $signed({1'b0, DEG_HALF});
      flip = 1'b1;
    end else begin
      deg  = $signed({1'b0, s1_r_q}) - $signed({1'b0, DEG_FULL});
      flip = 1'b0;
    end
    s2_rot_d.item = s1_item_q;
    s2_rot_d.pa   = flip ? -s1_pa_q : s1_pa_q;
    s2_rot_d.pb   = flip ? -s1_pb_q : s1_pb_q;
    s2_rot_d.ang  = AW'(deg) << 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= in_valid_i;
      if (s2_rdy) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      s1_item_q <= in_item_i;
      s1_r_q    <= s1_r_d;
      s1_pa_q   <= s1_pa_d;
      s1_pb_q   <= s1_pb_d;
    end
    if (s2_rdy && s1_v_q) begin
      s2_rot_q <= s2_rot_d;
    end
  end

  assign out_valid_o = s2_v_q;
  assign out_rot_o   = s2_rot_q;

  localparam logic signed [AW-1:0] ANG_MAX = AW'({1'b0, DEG_QUARTER}) << 16;

  a_reduced_in_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (s1_r_q < DEG_FULL))
    else $error("reduced angle outside one turn");

  a_folded_in_quarter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> ($signed(s2_rot_q.ang) <= ANG_MAX && $signed(s2_rot_q.ang) >= -ANG_MAX))
    else $error("folded angle outside a quarter turn");

endmodule

// ----- rtl/artv_cordic.sv -----
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage.
module artv_cordic import artv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  rot_t in_rot_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rot_t out_rot_o
);

  logic          v_q   [NSTG];
  rot_t          rot_q [NSTG];
  logic [NSTG:0] rdy;

  // A stage takes a new request when it is empty or its content moves on
  always_comb begin
    rdy[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN = AW'(atan_entry(i));
    logic                 src_v;
    rot_t                 src, nxt;
    logic signed [PW-1:0] da, db;

    if (i == 0) begin : g_first
      assign src_v = in_valid_i;
      assign src   = in_rot_i;
    end else begin : g_next
      assign src_v = v_q[i-1];
      assign src   = rot_q[i-1];
    end

    always_comb begin
      nxt = src;
      da  = $signed(src.pb) >>> i;
      db  = $signed(src.pa) >>> i;
      if (!src.ang[AW-1]) begin
        nxt.pa  = src.pa - da;
        nxt.pb  = src.pb + db;
        nxt.ang = src.ang - ATAN;
      end else begin
        nxt.pa  = src.pa + da;
        nxt.pb  = src.pb - db;
        nxt.ang = src.ang + ATAN;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_q[i] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && src_v) begin
        rot_q[i] <= nxt;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NSTG-1];
  assign out_rot_o   = rot_q[NSTG-1];

endmodule

// ----- rtl/artv_post.sv -----
// Rounding, translation, clipping and the output register.
module artv_post import artv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  rot_t in_rot_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  logic          out_v_q;
  res_t          res_q, res_d;
  logic [PW-1:0] wa, wb;
  logic [CW-1:0] t_sel;
  logic [CW+1:0] t_sum;
  clip_t         ca, cb, ct;
  item_t         it;

  assign in_ready_o = !out_v_q || out_ready_i;

  always_comb begin
    it = in_rot_i.item;
    // round half up to Q16.16
    wa = in_rot_i.pa + (PW'(1) << 15);
    wb = in_rot_i.pb + (PW'(1) << 15);
    ca = clip_coord(wa[PW-1:16]);
    cb = clip_coord(wb[PW-1:16]);

    case (it.kind)
      KIND_ADD_Y: t_sel = it.y;
      KIND_ADD_Z: t_sel = it.z;
      default:    t_sel = it.x;
    endcase
    t_sum = {{2{t_sel[CW-1]}}, t_sel} + {{2{it.amt[CW-1]}}, it.amt};
    ct    = clip_coord(t_sum);

    res_d.x   = it.x;
    res_d.y   = it.y;
    res_d.z   = it.z;
    res_d.sat = 1'b0;
    case (it.kind)
      KIND_ROT_X: begin
        res_d.y   = ca.val;
        res_d.z   = cb.val;
        res_d.sat = ca.sat | cb.sat;
      end
      KIND_ROT_Y: begin
        res_d.z   = ca.val;
        res_d.x   = cb.val;
        res_d.sat = ca.sat | cb.sat;
      end
      KIND_ROT_Z: begin
        res_d.x   = ca.val;
        res_d.y   = cb.val;
        res_d.sat = ca.sat | cb.sat;
      end
      KIND_ADD_X: begin
        res_d.x   = ct.val;
        res_d.sat = ct.sat;
      end
      KIND_ADD_Y: begin
        res_d.y   = ct.val;
        res_d.sat = ct.sat;
      end
      KIND_ADD_Z: begin
        res_d.z   = ct.val;
        res_d.sat = ct.sat;
      end
      default: begin
        res_d.sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (in_ready_o) begin
      out_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = res_q;

  localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && res_q.sat) |->
      (res_q.x == C_MAX || res_q.x == C_MIN || res_q.y == C_MAX || res_q.y == C_MIN ||
       res_q.z == C_MAX || res_q.z == C_MIN))
    else $error("saturated flag without a clipped component");

endmodule

// ----- rtl/axis_rotate_translate_vector.sv -----
// Top level: stream wrapper around the rotate/translate pipeline.
//
//  channel  | direction | handshake                    | payload
//  s_axis   | in        | s_axis_tvalid_i/tready_o     | tdata: x,y,z,amount; tuser: kind
//  m_axis   | out       | m_axis_tvalid_o/tready_i     | tdata: x,y,z; tuser: saturated
//
// One request enters per cycle unless an m_axis stall has filled every stage.
// Pipeline: two setup stages, one stage per CORDIC micro-rotation, one output register.
// The unrolled CORDIC stage chain makes up most of the pipeline.
// Reset clears only the valid bits; no state is kept between requests.
// A stall at m_axis holds the output; earlier stages keep filling bubbles and
// s_axis_tready_o drops only once every stage holds a request.
module axis_rotate_translate_vector import artv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // coord_x, coord_y, coord_z, amount
  input  logic [2:0]   s_axis_tuser_i,  // kind
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [95:0]  m_axis_tdata_o,  // result_x, result_y, result_z
  output logic         m_axis_tuser_o   // saturated
);

  item_t in_item;
  rot_t  prep_rot, cordic_rot;
  res_t  res;
  logic  prep_v, prep_rdy, cordic_v, cordic_rdy;

  assign in_item.kind = s_axis_tuser_i;
  assign in_item.x    = s_axis_tdata_i[31:0];
  assign in_item.y    = s_axis_tdata_i[63:32];
  assign in_item.z    = s_axis_tdata_i[95:64];
  assign in_item.amt  = s_axis_tdata_i[127:96];

  artv_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .out_valid_o (prep_v),
    .out_ready_i (prep_rdy),
    .out_rot_o   (prep_rot)
  );

  artv_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_v),
    .in_ready_o  (prep_rdy),
    .in_rot_i    (prep_rot),
    .out_valid_o (cordic_v),
    .out_ready_i (cordic_rdy),
    .out_rot_o   (cordic_rot)
  );

  artv_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cordic_v),
    .in_ready_o  (cordic_rdy),
    .in_rot_i    (cordic_rot),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tdata_o = {res.z, res.y, res.x};
  assign m_axis_tuser_o = res.sat;

  a_backpressure_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled while the output side is free");

endmodule

// ----- tb/sv/tb_axis_rotate_translate_vector.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the stream axis rotate/translate vector pipeline.
module tb_axis_rotate_translate_vector;
  import artv_pkg::*;

  localparam int ONE = 65536;  // 1.0 in Q16.16, also one degree
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  localparam longint TURN_Q16 = 64'sd360 * 65536;
  localparam longint HALF_TURN_Q16 = 64'sd180 * 65536;
  localparam longint QUARTER_TURN_Q16 = 64'sd90 * 65536;
  localparam longint DEG_PER_RAD_Q32 = 64'sd246083499208;
  localparam longint INV_GAIN_LIMIT_Q32 = 64'sd2608131496;
  localparam longint ARCTAN_Q32 [16] = '{
    64'sd193273528320, 64'sd114096026022, 64'sd60285206653, 64'sd30601712202,
    64'sd15360239180, 64'sd7687607525, 64'sd3844741810, 64'sd1922488225,
    64'sd961258780, 64'sd480631223, 64'sd240315841, 64'sd120157949,
    64'sd60078978, 64'sd30039489, 64'sd15019745, 64'sd7509872
  };
  localparam longint INV_GAIN_Q32 [9] = '{
    64'sd2608158028, 64'sd2608138129, 64'sd2608133154, 64'sd2608131911,
    64'sd2608131600, 64'sd2608131522, 64'sd2608131503, 64'sd2608131498,
    64'sd2608131497
  };

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] amt;
  } vec_req_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } vec_res_t;

  class vec_scoreboard;
    vec_res_t pending_vectors[$];
    int       failures;

    function new();
      failures = 0;
    endfunction

    // Rotate (a, b) counterclockwise by amt degrees with a fixed-point CORDIC
    function void turn_pair(inout longint a, inout longint b, input longint amt);
      longint r, ang, g, pa, pb, da, db, step_ang;
      bit     flip;
      r = amt % TURN_Q16;
      if (r < 0) r += TURN_Q16;
      if (r > HALF_TURN_Q16) r -= TURN_Q16;
      flip = 1'b0;
      if (r > QUARTER_TURN_Q16) begin
        r -= HALF_TURN_Q16;
        flip = 1'b1;
      end else if (r < -QUARTER_TURN_Q16) begin
        r += HALF_TURN_Q16;
        flip = 1'b1;
      end
      ang = r * 65536;
      g = (NSTG >= 17) ? INV_GAIN_LIMIT_Q32 : INV_GAIN_Q32[NSTG - 8];
      pa = (a * g) >>> 16;
      pb = (b * g) >>> 16;
      if (flip) begin
        pa = -pa;
        pb = -pb;
      end
      for (int i = 0; i < NSTG; i++) begin
        if (i < 16) step_ang = ARCTAN_Q32[i];
        else step_ang = (DEG_PER_RAD_Q32 + (64'sd1 <<< (i - 1))) >>> i;
        da = pb >>> i;
        db = pa >>> i;
        if (ang >= 0) begin
          pa -= da;
          pb += db;
          ang -= step_ang;
        end else begin
          pa += da;
          pb -= db;
          ang += step_ang;
        end
      end
      a = (pa + 32768) >>> 16;
      b = (pb + 32768) >>> 16;
    endfunction

    function logic signed [31:0] clip_q16(input longint v, inout bit sat);
      if (v > longint'(Q_MAX)) begin
        sat = 1'b1;
        return Q_MAX;
      end
      if (v < longint'(Q_MIN)) begin
        sat = 1'b1;
        return Q_MIN;
      end
      return v[31:0];
    endfunction

    function vec_res_t transform_vector(input vec_req_t q);
      longint   x, y, z;
      bit       sat;
      vec_res_t r;
      x = q.x;
      y = q.y;
      z = q.z;
      sat = 1'b0;
      case (q.kind)
        KIND_ROT_X: turn_pair(y, z, q.amt);
        KIND_ROT_Y: turn_pair(z, x, q.amt);
        KIND_ROT_Z: turn_pair(x, y, q.amt);
        KIND_ADD_X: x += q.amt;
        KIND_ADD_Y: y += q.amt;
        KIND_ADD_Z: z += q.amt;
        default: ;
      endcase
      r.x = clip_q16(x, sat);
      r.y = clip_q16(y, sat);
      r.z = clip_q16(z, sat);
      r.sat = sat;
      return r;
    endfunction

    function void note_request(input vec_req_t q);
      pending_vectors.push_back(transform_vector(q));
    endfunction

    function void check_vector(input vec_res_t got);
      vec_res_t want;
      if (pending_vectors.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d sat=%0b", got.x, got.y, got.z, got.sat);
        failures++;
        return;
      end
      want = pending_vectors.pop_front();
      if (got.x !== want.x) begin
        $error("result_x: expected %0d, got %0d", want.x, got.x);
        failures++;
      end
      if (got.y !== want.y) begin
        $error("result_y: expected %0d, got %0d", want.y, got.y);
        failures++;
      end
      if (got.z !== want.z) begin
        $error("result_z: expected %0d, got %0d", want.z, got.z);
        failures++;
      end
      if (got.sat !== want.sat) begin
        $error("saturated: expected %0b, got %0b", want.sat, got.sat);
        failures++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic         m_tuser;

  logic          calm = 1'b0;  // no idling on either side while set
  int            sink_hold = 0;
  int            sink_roll;
  vec_scoreboard sb;
  vec_res_t      seen;

  axis_rotate_translate_vector dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // coord_x, coord_y, coord_z, amount
    .s_axis_tuser_i  (s_tuser),   // kind
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // result_x, result_y, result_z
    .m_axis_tuser_o  (m_tuser)    // saturated
  );

  always #10 clk = ~clk;

  // Sink side: short random stalls plus a rare long one
  always @(posedge clk) begin
    if (calm) begin
      m_tready <= 1'b1;
    end else if (sink_hold != 0) begin
      sink_hold--;
      m_tready <= 1'b0;
    end else begin
      sink_roll = $urandom_range(999);
      if (sink_roll < 1) begin
        sink_hold = $urandom_range(36, 24);
        m_tready <= 1'b0;
      end else begin
        m_tready <= (sink_roll >= 81);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      seen.x = m_tdata[31:0];
      seen.y = m_tdata[63:32];
      seen.z = m_tdata[95:64];
      seen.sat = m_tuser;
      sb.check_vector(seen);
    end
  end

  task automatic send_vector(input logic [2:0] kind, input logic signed [31:0] vx,
                             input logic signed [31:0] vy, input logic signed [31:0] vz,
                             input logic signed [31:0] amt);
    vec_req_t q;
    int       roll;
    q.kind = kind;
    q.x = vx;
    q.y = vy;
    q.z = vz;
    q.amt = amt;
    s_tvalid <= 1'b1;
    s_tdata <= {amt, vz, vy, vx};
    s_tuser <= kind;
    do @(posedge clk); while (!s_tready);
    sb.note_request(q);
    // Insert a gap now and then
    roll = $urandom_range(99);
    if (!calm && roll < 11) begin
      s_tvalid <= 1'b0;
      s_tdata <= {$urandom, $urandom, $urandom, $urandom};
      s_tuser <= 3'($urandom_range(7));
      repeat ((roll == 0) ? $urandom_range(15, 5) : $urandom_range(2, 1)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return $signed($urandom_range(2000 * ONE)) - 1000 * ONE;
      8: begin
        case ($urandom_range(4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return $urandom_range(1) ? Q_MAX - $urandom_range(255)
                                        : Q_MIN + $urandom_range(255);
    endcase
  endfunction

  function automatic logic signed [31:0] random_angle();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(1440 * ONE)) - 720 * ONE;
      // Hit the quarter-turn folding boundaries
      2: return 90 * ONE * ($signed($urandom_range(16)) - 8) + $signed($urandom_range(4)) - 2;
      default: return $signed($urandom_range(180 * ONE)) - 90 * ONE;
    endcase
  endfunction

  initial begin
    logic [2:0] kind;
    int         roll;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_vector(KIND_ROT_X, ONE, 2 * ONE, 3 * ONE, 0);
    send_vector(KIND_ROT_X, ONE, 2 * ONE, 3 * ONE, 90 * ONE);
    send_vector(KIND_ROT_X, ONE, 2 * ONE, 3 * ONE, 90 * ONE + 1);
    send_vector(KIND_ROT_Y, 5 * ONE, -7 * ONE, 11 * ONE, -90 * ONE);
    send_vector(KIND_ROT_Y, 5 * ONE, -7 * ONE, 11 * ONE, -90 * ONE - 1);
    send_vector(KIND_ROT_Y, 5 * ONE, -7 * ONE, 11 * ONE, 180 * ONE);
    send_vector(KIND_ROT_Z, 3 * ONE, 4 * ONE, ONE, -180 * ONE);
    send_vector(KIND_ROT_Z, 3 * ONE, 4 * ONE, ONE, 360 * ONE);
    send_vector(KIND_ROT_Z, Q_MAX, Q_MAX, 0, 45 * ONE);
    send_vector(KIND_ROT_X, Q_MIN, Q_MIN, Q_MIN, Q_MAX);
    send_vector(KIND_ROT_Y, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    send_vector(KIND_ROT_Z, Q_MIN, Q_MIN, 0, 225 * ONE);
    send_vector(KIND_ROT_X, 0, 0, 0, 270 * ONE);
    send_vector(KIND_ROT_Z, -1, 1, 0, -30 * ONE);
    send_vector(KIND_ADD_X, Q_MAX, 0, 0, 1);
    send_vector(KIND_ADD_X, Q_MIN, 0, 0, -1);
    send_vector(KIND_ADD_Y, 0, Q_MAX, 0, Q_MIN);
    send_vector(KIND_ADD_Y, 0, Q_MIN, 0, Q_MIN);
    send_vector(KIND_ADD_Z, 0, 0, Q_MAX, Q_MAX);
    send_vector(KIND_ADD_Z, 1, 2, Q_MAX - 5, 5);
    send_vector(KIND_SPARE_A, Q_MAX, Q_MIN, -1, Q_MAX);
    send_vector(KIND_SPARE_B, Q_MIN, Q_MAX, 1, Q_MIN);

    // Hold off until the pipeline has drained
    s_tvalid <= 1'b0;
    while (sb.pending_vectors.size() != 0) @(posedge clk);

    for (int n = 0; n < 850; n++) begin
      if (n == 300) calm <= 1'b1;
      if (n == 450) calm <= 1'b0;
      roll = $urandom_range(99);
      if (roll < 4) kind = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
      else kind = 3'($urandom_range(5));
      if (kind <= KIND_ROT_Z)
        send_vector(kind, random_coord(), random_coord(), random_coord(), random_angle());
      else
        send_vector(kind, random_coord(), random_coord(), random_coord(), random_coord());
    end
    s_tvalid <= 1'b0;

    while (sb.pending_vectors.size() != 0) @(posedge clk);
    repeat (NSTG + 13) @(posedge clk);
    if (sb.failures == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
